// ----- rtl/pbeq_pkg.sv -----
// Package for the preset biquad equalizer: widths, coefficient set codes,
// the request item passed from front to back, the back sequencer states,
// and the coefficient ROM. No dependencies.
package pbeq_pkg;

   // Sample and datapath widths.
   localparam int SAMPLE_BITS = 16;
   localparam int DATA_BITS   = 32;
   localparam int COEF_BITS   = 18;
   localparam int FRAC_BITS   = 15;
   localparam int PROD_BITS   = COEF_BITS + DATA_BITS;
   // Only bits up to FRAC_BITS + DATA_BITS of the exact sum reach the wrapped result.
   localparam int ACC_BITS    = DATA_BITS + FRAC_BITS;
   localparam int PRESET_BITS = 4;

   // Multiply-accumulate sequencing: five terms, then one drain step.
   localparam int NUM_TERMS   = 5;
   localparam int STEP_BITS   = $clog2(NUM_TERMS + 1);

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Preset register codes; undefined codes act as bypass.
   typedef enum logic [PRESET_BITS-1:0] {
      PRESET_BYPASS       = 4'd0,
      PRESET_BASS_BOOST   = 4'd1,
      PRESET_BASS_CUT     = 4'd2,
      PRESET_TREBLE_BOOST = 4'd3,
      PRESET_TREBLE_CUT   = 4'd4,
      PRESET_VOCAL        = 4'd5,
      PRESET_ROCK         = 4'd6,
      PRESET_POP          = 4'd7,
      PRESET_JAZZ         = 4'd8,
      PRESET_LOW_PASS     = 4'd9,
      PRESET_HIGH_PASS    = 4'd10
   } preset_type;

   // Coefficient set codes in the ROM.
   typedef enum logic [2:0] {
      SET_BYPASS,
      SET_BASS_BOOST,
      SET_BASS_CUT,
      SET_TREBLE_BOOST,
      SET_TREBLE_CUT,
      SET_VOCAL,
      SET_LOW_PASS,
      SET_HIGH_PASS
   } coef_set_type;

   // Terms of one biquad sum, in issue order.
   typedef enum logic [STEP_BITS-1:0] {
      TERM_B0,
      TERM_B1,
      TERM_B2,
      TERM_A1,
      TERM_A2
   } term_type;

   // States of the back sequencer.
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MAC,
      BK_STORE,
      BK_DONE
   } back_state_type;

   // One classified request as it travels through the queue.
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      coef_set_type                  first_set;
      coef_set_type                  second_set;
      logic                          two_stage;
   } item_type;

   // Coefficient ROM. Feedback terms are stored negated so that every
   // term is added.
   function automatic logic signed [COEF_BITS-1:0] coef_lookup(
      input coef_set_type set_sel,
      input term_type     term
   );
      int b0;
      int b1;
      int b2;
      int na1;
      int na2;
      int v;
      case (set_sel)
         SET_BASS_BOOST: begin
            b0 = 34852; b1 = -62665; b2 = 28105; na1 = 62976; na2 = -30493;
         end
         SET_BASS_CUT: begin
            b0 = 30811; b1 = -58923; b2 = 28341; na1 = 59152; na2 = -26614;
         end
         SET_TREBLE_BOOST: begin
            b0 = 40130; b1 = -51416; b2 = 20312; na1 = 45537; na2 = -18523;
         end
         SET_TREBLE_CUT: begin
            b0 = 26761; b1 = -37185; b2 = 15119; na1 = 41848; na2 = -13772;
         end
         SET_VOCAL: begin
            b0 = 35032; b1 = -47651; b2 = 18890; na1 = 47651; na2 = -21155;
         end
         SET_LOW_PASS: begin
            b0 = 3198; b1 = 6399; b2 = 3198; na1 = 30893; na2 = -10921;
         end
         SET_HIGH_PASS: begin
            b0 = 30772; b1 = -61544; b2 = 30772; na1 = 61423; na2 = -28898;
         end
         default: begin
            b0 = 32768; b1 = 0; b2 = 0; na1 = 0; na2 = 0;
         end
      endcase
      case (term)
         TERM_B0: v = b0;
         TERM_B1: v = b1;
         TERM_B2: v = b2;
         TERM_A1: v = na1;
         TERM_A2: v = na2;
         default: v = 0;
      endcase
      return COEF_BITS'(v);
   endfunction

endpackage

// ----- rtl/pbeq_front.sv -----
// Front of the equalizer: holds the preset register, classifies each
// request into coefficient sets and stage count, and pushes it to the queue.
// Depends on pbeq_pkg.
module pbeq_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [pbeq_pkg::PRESET_BITS-1:0]       csr_preset,
   input  logic                                   push,
   input  logic signed [pbeq_pkg::SAMPLE_BITS-1:0] req_in_sample,
   output logic                                   full,
   input  logic                                   q_full,
   output logic                                   q_push,
   output pbeq_pkg::item_type                     q_item
);
   import pbeq_pkg::*;

   logic [PRESET_BITS-1:0] preset_ff;
   logic [PRESET_BITS-1:0] preset_in;
   coef_set_type           first_set;
   coef_set_type           second_set;
   logic                   two_stage;

   // Preset register, written from the configuration port.
   always_comb begin
      preset_in = csr_write ? csr_preset : preset_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preset_ff <= PRESET_BYPASS;
      end else begin
         preset_ff <= preset_in;
      end
   end

   // Map the preset to the sets used by each stage.
   always_comb begin
      first_set  = SET_BYPASS;
      second_set = SET_BYPASS;
      two_stage  = 1'b0;
      case (preset_type'(preset_ff))
         PRESET_BASS_BOOST:   first_set = SET_BASS_BOOST;
         PRESET_BASS_CUT:     first_set = SET_BASS_CUT;
         PRESET_TREBLE_BOOST: first_set = SET_TREBLE_BOOST;
         PRESET_TREBLE_CUT:   first_set = SET_TREBLE_CUT;
         PRESET_VOCAL:        first_set = SET_VOCAL;
         PRESET_ROCK: begin
            first_set  = SET_BASS_BOOST;
            second_set = SET_TREBLE_BOOST;
            two_stage  = 1'b1;
         end
         PRESET_POP: begin
            first_set  = SET_VOCAL;
            second_set = SET_TREBLE_BOOST;
            two_stage  = 1'b1;
         end
         PRESET_JAZZ: begin
            first_set  = SET_BASS_BOOST;
            second_set = SET_TREBLE_CUT;
            two_stage  = 1'b1;
         end
         PRESET_LOW_PASS:     first_set = SET_LOW_PASS;
         PRESET_HIGH_PASS:    first_set = SET_HIGH_PASS;
         default:             first_set = SET_BYPASS;
      endcase
   end

   // Accept a request whenever the queue has room.
   assign full              = q_full;
   assign q_push            = push && !q_full;
   assign q_item.sample     = req_in_sample;
   assign q_item.first_set  = first_set;
   assign q_item.second_set = second_set;
   assign q_item.two_stage  = two_stage;

endmodule

// ----- rtl/pbeq_queue.sv -----
// Short request queue between the equalizer front and back.
// Depends on pbeq_pkg.
module pbeq_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_push,
   input  pbeq_pkg::item_type q_item,
   input  logic               q_pop,
   output logic               q_full,
   output logic               q_empty,
   output pbeq_pkg::item_type q_head
);
   import pbeq_pkg::*;

   item_type               entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff;
   logic [QPTR_BITS-1:0]   wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff;
   logic [QPTR_BITS-1:0]   rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff;
   logic [QCNT_BITS-1:0]   count_in;

   assign q_full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign q_head  = entries_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (q_push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !q_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (q_push) begin
         entries_ff[wr_ptr_ff] <= q_item;
      end
   end

endmodule

// ----- rtl/pbeq_back.sv -----
// Back of the equalizer: runs one or two biquad stages through a shared
// multiplier and accumulator, keeps the filter histories, and holds the
// saturated result for the response side. Depends on pbeq_pkg.
module pbeq_back (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    hist_clear,
   input  logic                                    q_empty,
   input  pbeq_pkg::item_type                      q_head,
   output logic                                    q_pop,
   output logic                                    empty,
   input  logic                                    pop,
   output logic signed [pbeq_pkg::SAMPLE_BITS-1:0] rsp_out_sample
);
   import pbeq_pkg::*;

   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(NUM_TERMS);

   back_state_type state_ff;
   back_state_type state_in;

   logic [STEP_BITS-1:0]          step_ff;
   logic [STEP_BITS-1:0]          step_in;
   logic                          stage_ff;
   logic                          stage_in;
   item_type                      item_ff;
   item_type                      item_in;
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic signed [PROD_BITS-1:0]   prod_in;
   logic [ACC_BITS-1:0]           acc_ff;
   logic [ACC_BITS-1:0]           acc_in;
   logic signed [DATA_BITS-1:0]   stage_x_ff;
   logic signed [DATA_BITS-1:0]   stage_x_in;
   logic signed [DATA_BITS-1:0]   result_ff;
   logic signed [DATA_BITS-1:0]   result_in;

   // Filter histories.
   logic signed [SAMPLE_BITS-1:0] x1_a_ff, x2_a_ff, x1_a_in, x2_a_in;
   logic signed [DATA_BITS-1:0]   y1_a_ff, y2_a_ff, y1_a_in, y2_a_in;
   logic signed [DATA_BITS-1:0]   x1_b_ff, x2_b_ff, x1_b_in, x2_b_in;
   logic signed [DATA_BITS-1:0]   y1_b_ff, y2_b_ff, y1_b_in, y2_b_in;

   // Response register.
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_data_in;

   // Control strobes.
   logic                          issue;
   logic                          accum;
   logic                          store;
   logic                          chain;
   logic                          out_free;
   logic                          out_load;

   // Datapath signals.
   logic signed [DATA_BITS-1:0]   operand;
   logic signed [COEF_BITS-1:0]   coef;
   coef_set_type                  cur_set;
   logic signed [DATA_BITS-1:0]   stage_y;
   logic signed [SAMPLE_BITS-1:0] sat_y;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:  if (!q_empty) state_in = BK_MAC;
         BK_MAC:   if (step_ff == LAST_STEP) state_in = BK_STORE;
         BK_STORE: begin
            if (!stage_ff && item_ff.two_stage) begin
               state_in = BK_MAC;
            end else begin
               state_in = BK_DONE;
            end
         end
         BK_DONE:  if (out_free) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   assign out_free = !rsp_valid_ff || pop;

   always_comb begin
      q_pop    = 1'b0;
      issue    = 1'b0;
      accum    = 1'b0;
      store    = 1'b0;
      chain    = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         BK_IDLE:  q_pop = !q_empty;
         BK_MAC: begin
            issue = (step_ff != LAST_STEP);
            accum = (step_ff != '0);
         end
         BK_STORE: begin
            store = 1'b1;
            chain = !stage_ff && item_ff.two_stage;
         end
         BK_DONE:  out_load = out_free;
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // Operand and coefficient for the term being issued.
   assign cur_set = stage_ff ? item_ff.second_set : item_ff.first_set;
   assign coef    = coef_lookup(cur_set, term_type'(step_ff));

   always_comb begin
      case (term_type'(step_ff))
         TERM_B0: operand = stage_ff ? stage_x_ff : DATA_BITS'(item_ff.sample);
         TERM_B1: operand = stage_ff ? x1_b_ff : DATA_BITS'(x1_a_ff);
         TERM_B2: operand = stage_ff ? x2_b_ff : DATA_BITS'(x2_a_ff);
         TERM_A1: operand = stage_ff ? y1_b_ff : y1_a_ff;
         TERM_A2: operand = stage_ff ? y2_b_ff : y2_a_ff;
         default: operand = '0;
      endcase
   end

   // The stage output is the sum shifted right by the fraction bits and
   // wrapped to the data width.
   assign stage_y = acc_ff[ACC_BITS-1:FRAC_BITS];

   // Saturate the final value to the sample range.
   always_comb begin
      if (result_ff[DATA_BITS-1:SAMPLE_BITS-1] == '0 ||
          result_ff[DATA_BITS-1:SAMPLE_BITS-1] == '1) begin
         sat_y = result_ff[SAMPLE_BITS-1:0];
      end else if (result_ff[DATA_BITS-1]) begin
         sat_y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         sat_y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

   // Next values of the datapath registers.
   always_comb begin
      step_in      = step_ff;
      stage_in     = stage_ff;
      item_in      = item_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      stage_x_in   = stage_x_ff;
      result_in    = result_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;

      if (q_pop) begin
         item_in  = q_head;
         stage_in = 1'b0;
         step_in  = '0;
         acc_in   = '0;
      end else if (chain) begin
         stage_in   = 1'b1;
         step_in    = '0;
         acc_in     = '0;
         stage_x_in = stage_y;
      end else if (state_ff == BK_MAC) begin
         step_in = step_ff + 1'b1;
      end

      if (issue) begin
         prod_in = coef * operand;
      end
      if (accum) begin
         acc_in = acc_ff + prod_ff[ACC_BITS-1:0];
      end
      if (store) begin
         result_in = stage_y;
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = sat_y;
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Next values of the histories.
   always_comb begin
      x1_a_in = x1_a_ff;
      x2_a_in = x2_a_ff;
      y1_a_in = y1_a_ff;
      y2_a_in = y2_a_ff;
      x1_b_in = x1_b_ff;
      x2_b_in = x2_b_ff;
      y1_b_in = y1_b_ff;
      y2_b_in = y2_b_ff;
      if (hist_clear) begin
         x1_a_in = '0;
         x2_a_in = '0;
         y1_a_in = '0;
         y2_a_in = '0;
         x1_b_in = '0;
         x2_b_in = '0;
         y1_b_in = '0;
         y2_b_in = '0;
      end else if (store && !stage_ff) begin
         x1_a_in = item_ff.sample;
         x2_a_in = x1_a_ff;
         y1_a_in = stage_y;
         y2_a_in = y1_a_ff;
      end else if (store) begin
         x1_b_in = stage_x_ff;
         x2_b_in = x1_b_ff;
         y1_b_in = stage_y;
         y2_b_in = y1_b_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         stage_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         stage_ff     <= stage_in;
      end
   end

   // History registers, cleared by reset and by a preset write.
   always_ff @(posedge clock) begin
      if (reset) begin
         x1_a_ff <= '0;
         x2_a_ff <= '0;
         y1_a_ff <= '0;
         y2_a_ff <= '0;
         x1_b_ff <= '0;
         x2_b_ff <= '0;
         y1_b_ff <= '0;
         y2_b_ff <= '0;
      end else begin
         x1_a_ff <= x1_a_in;
         x2_a_ff <= x2_a_in;
         y1_a_ff <= y1_a_in;
         y2_a_ff <= y2_a_in;
         x1_b_ff <= x1_b_in;
         x2_b_ff <= x2_b_in;
         y1_b_ff <= y1_b_in;
         y2_b_ff <= y2_b_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      stage_x_ff  <= stage_x_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign empty          = !rsp_valid_ff;
   assign rsp_out_sample = rsp_data_ff;

endmodule

// ----- rtl/preset_biquad_equalizer.sv -----
// A request passes through the queue, then the back states idle, multiply-accumulate
// and store, once per stage (two stages for the rock, pop and jazz presets), then done.
// The back works on one request at a time and takes no new one until the result is
// loaded; the single shared 18x32 multiplier runs five terms per stage plus drain.
// A two-entry queue takes requests while the back is busy.
// Reset is synchronous and active high: preset returns to bypass, all filter
// histories and the queue clear; a preset write also clears the histories.
module preset_biquad_equalizer (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    push,
   output logic                                    full,
   input  logic signed [pbeq_pkg::SAMPLE_BITS-1:0] req_in_sample,
   output logic                                    empty,
   input  logic                                    pop,
   output logic signed [pbeq_pkg::SAMPLE_BITS-1:0] rsp_out_sample,
   input  logic                                    csr_write,
   input  logic [pbeq_pkg::PRESET_BITS-1:0]        csr_preset
);
   import pbeq_pkg::*;

   logic     q_push;
   logic     q_pop;
   logic     q_full;
   logic     q_empty;
   item_type q_item;
   item_type q_head;

   // Front: preset register and request classification.
   pbeq_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_preset    (csr_preset),
      .push          (push),
      .req_in_sample (req_in_sample),
      .full          (full),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (q_item)
   );

   // Queue between front and back.
   pbeq_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_item  (q_item),
      .q_pop   (q_pop),
      .q_full  (q_full),
      .q_empty (q_empty),
      .q_head  (q_head)
   );

   // Back: shared multiply-accumulate, histories and response register.
   pbeq_back u_back (
      .clock          (clock),
      .reset          (reset),
      .hist_clear     (csr_write),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .empty          (empty),
      .pop            (pop),
      .rsp_out_sample (rsp_out_sample)
   );

   // The queue is never full and empty at once.
   assert property (@(posedge clock) disable iff (reset) !(q_full && q_empty))
      else $error("request queue reports full and empty together");

   // The back only takes a request that is there.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("back popped an empty request queue");

   // A request taken into an empty queue is visible to the back next cycle.
   assert property (@(posedge clock) disable iff (reset)
                    (q_push && q_empty && !q_pop) |=> !q_empty)
      else $error("accepted request lost in the queue");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for preset_biquad_equalizer: queue-style request and
// result channels, preset writes between phases, and a scoreboard that models
// the Q15 biquad cascade. Depends on pbeq_pkg and the equalizer RTL.
module testbench;
   import pbeq_pkg::*;

   // Unused preset code at the top of the range; the block treats it as bypass.
   localparam logic [PRESET_BITS-1:0] PRESET_LAST_CODE = 4'd15;
   localparam int SAMPLE_MAX     = 32767;
   localparam int SAMPLE_MIN     = -32768;
   localparam int PHASES         = 18;
   localparam int PHASE_REQUESTS = 55;
   localparam int BLOCK_LATENCY  = 16;

   // One coefficient set in the sign convention y = b.x - a.y.
   typedef struct {
      longint b0;
      longint b1;
      longint b2;
      longint a1;
      longint a2;
   } coef_taps_type;

   // Scoreboard: tracks the preset and the filter histories, predicts each
   // filtered sample when a request is accepted and checks results in order.
   class filter_scoreboard;
      logic [PRESET_BITS-1:0]        preset;
      int                            in_hist[2][2];
      int                            out_hist[2][2];
      logic signed [SAMPLE_BITS-1:0] expected_samples[$];
      int                            errors;
      int                            checked;
      int                            requests;

      function new();
         preset   = PRESET_BYPASS;
         errors   = 0;
         checked  = 0;
         requests = 0;
         clear_history();
      endfunction

      function void clear_history();
         for (int st = 0; st < 2; st++) begin
            for (int i = 0; i < 2; i++) begin
               in_hist[st][i]  = 0;
               out_hist[st][i] = 0;
            end
         end
      endfunction

      // Every preset write clears both stages, even a rewrite of the same value.
      function void set_preset(logic [PRESET_BITS-1:0] p);
         preset = p;
         clear_history();
      endfunction

      function coef_taps_type taps_of(coef_set_type s);
         coef_taps_type t;
         case (s)
            SET_BASS_BOOST:   t = '{34852, -62665, 28105, -62976, 30493};
            SET_BASS_CUT:     t = '{30811, -58923, 28341, -59152, 26614};
            SET_TREBLE_BOOST: t = '{40130, -51416, 20312, -45537, 18523};
            SET_TREBLE_CUT:   t = '{26761, -37185, 15119, -41848, 13772};
            SET_VOCAL:        t = '{35032, -47651, 18890, -47651, 21155};
            SET_LOW_PASS:     t = '{3198, 6399, 3198, -30893, 10921};
            SET_HIGH_PASS:    t = '{30772, -61544, 30772, -61423, 28898};
            default:          t = '{32768, 0, 0, 0, 0};
         endcase
         return t;
      endfunction

      // One biquad stage: exact sum, arithmetic shift by 15, wrap to 32 bits.
      function int run_stage(int st, coef_set_type s, int x);
         coef_taps_type t;
         longint        acc;
         int            y;
         t   = taps_of(s);
         acc = t.b0 * x + t.b1 * in_hist[st][0] + t.b2 * in_hist[st][1]
             - t.a1 * out_hist[st][0] - t.a2 * out_hist[st][1];
         y   = int'(acc >>> 15);
         in_hist[st][1]  = in_hist[st][0];
         in_hist[st][0]  = x;
         out_hist[st][1] = out_hist[st][0];
         out_hist[st][0] = y;
         return y;
      endfunction

      function logic signed [SAMPLE_BITS-1:0] filter_sample(
         logic signed [SAMPLE_BITS-1:0] s
      );
         coef_set_type first_set;
         coef_set_type second_set;
         bit           cascade;
         int           y;
         first_set  = SET_BYPASS;
         second_set = SET_BYPASS;
         cascade    = 1'b0;
         // Codes without a curve fall through to bypass.
         case (preset)
            PRESET_BASS_BOOST:   first_set = SET_BASS_BOOST;
            PRESET_BASS_CUT:     first_set = SET_BASS_CUT;
            PRESET_TREBLE_BOOST: first_set = SET_TREBLE_BOOST;
            PRESET_TREBLE_CUT:   first_set = SET_TREBLE_CUT;
            PRESET_VOCAL:        first_set = SET_VOCAL;
            PRESET_ROCK: begin
               first_set  = SET_BASS_BOOST;
               second_set = SET_TREBLE_BOOST;
               cascade    = 1'b1;
            end
            PRESET_POP: begin
               first_set  = SET_VOCAL;
               second_set = SET_TREBLE_BOOST;
               cascade    = 1'b1;
            end
            PRESET_JAZZ: begin
               first_set  = SET_BASS_BOOST;
               second_set = SET_TREBLE_CUT;
               cascade    = 1'b1;
            end
            PRESET_LOW_PASS:     first_set = SET_LOW_PASS;
            PRESET_HIGH_PASS:    first_set = SET_HIGH_PASS;
            default: ;
         endcase
         y = run_stage(0, first_set, int'(s));
         if (cascade)
            y = run_stage(1, second_set, y);
         // Saturate the wrapped stage output to the sample range.
         if (y > SAMPLE_MAX)
            y = SAMPLE_MAX;
         else if (y < SAMPLE_MIN)
            y = SAMPLE_MIN;
         return y[SAMPLE_BITS-1:0];
      endfunction

      function void note_request(logic signed [SAMPLE_BITS-1:0] s);
         requests++;
         expected_samples.push_back(filter_sample(s));
      endfunction

      function void check_result(logic signed [SAMPLE_BITS-1:0] actual);
         logic signed [SAMPLE_BITS-1:0] want;
         if (expected_samples.size() == 0) begin
            errors++;
            $error("out_sample with no request pending: expected none, actual %0d", actual);
            return;
         end
         want = expected_samples.pop_front();
         checked++;
         if (actual !== want) begin
            errors++;
            $error("out_sample mismatch: expected %0d, actual %0d", want, actual);
         end
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          push;
   logic                          full;
   logic signed [SAMPLE_BITS-1:0] req_in_sample;
   logic                          empty;
   logic                          pop;
   logic signed [SAMPLE_BITS-1:0] rsp_out_sample;
   logic                          csr_write;
   logic [PRESET_BITS-1:0]        csr_preset;

   int                            send_idle_pct;
   int                            take_idle_pct;
   logic [15:0]                   presets_seen;
   bit                            square_high;
   filter_scoreboard              sb;

   preset_biquad_equalizer DUT (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_in_sample  (req_in_sample),
      .empty          (empty),
      .pop            (pop),
      .rsp_out_sample (rsp_out_sample),
      .csr_write      (csr_write),
      .csr_preset     (csr_preset)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #5_000_000;
      $display("testbench failed");
      $finish;
   end

   // Observe both handshakes on the pre-edge values.
   always @(posedge clock) begin
      if (!reset && push && !full)
         sb.note_request(req_in_sample);
      if (!reset && pop && !empty)
         sb.check_result(rsp_out_sample);
   end

   // The result side pops at random, at the rate of the current phase.
   initial begin
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         pop <= !reset && ($urandom_range(99) >= take_idle_pct);
      end
   end

   // Offer one request and hold it until the block takes it. Push stays high
   // on return so that back-to-back requests need no second assignment.
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push          <= 1'b1;
      req_in_sample <= s;
      @(posedge clock);
      while (full)
         @(posedge clock);
   endtask

   // Stop sending and wait until every expected result has been taken.
   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (BLOCK_LATENCY) @(posedge clock);
   endtask

   task automatic write_preset(input logic [PRESET_BITS-1:0] p);
      drain();
      csr_write  <= 1'b1;
      csr_preset <= p;
      @(posedge clock);
      csr_write <= 1'b0;
      sb.set_preset(p);
      presets_seen[p] = 1'b1;
   endtask

   // Mix of full-range noise, extremes, small signals and loud square waves.
   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      int v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = int'($urandom);
         4, 5:       v = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
         6, 7:       v = int'($urandom_range(511)) - 256;
         default: begin
            square_high = !square_high;
            v = int'($urandom_range(SAMPLE_MAX, 24000));
            if (!square_high)
               v = -v - 1;
         end
      endcase
      return v[SAMPLE_BITS-1:0];
   endfunction

   initial begin
      int k;
      int n;
      sb = new();
      reset         <= 1'b1;
      push          <= 1'b0;
      req_in_sample <= '0;
      csr_write     <= 1'b0;
      csr_preset    <= '0;
      send_idle_pct = 0;
      take_idle_pct = 0;
      presets_seen  = 16'h0001;
      square_high   = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Bypass with the sample extremes.
      write_preset(PRESET_BYPASS);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh0000);
      send_sample(16'sh0001);
      send_sample(16'shFFFF);

      // Full-scale alternation drives the high-pass into saturation.
      write_preset(PRESET_HIGH_PASS);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);

      // A cascade, then the same preset written again must restart from zero.
      write_preset(PRESET_ROCK);
      repeat (3) send_sample(16'sh7FFF);
      write_preset(PRESET_ROCK);
      repeat (3) send_sample(16'sh7FFF);

      // An unused code acts as bypass.
      write_preset(PRESET_LAST_CODE);
      send_sample(16'sh8000);
      send_sample(16'sh1234);
      send_sample(16'sh7FFF);

      write_preset(PRESET_LOW_PASS);
      repeat (3) send_sample(16'sh8000);

      // Random phases: every preset code, under three idling patterns.
      for (k = 0; k < PHASES; k++) begin
         send_idle_pct = (k < 6) ? 15 : (k < 12) ? 69 : 0;
         take_idle_pct = (k < 6) ? 69 : (k < 12) ? 15 : 0;
         if (k < 16)
            write_preset(4'((k * 7) % 16));
         else
            write_preset(4'($urandom_range(15)));
         for (n = 0; n < PHASE_REQUESTS; n++)
            send_sample(random_sample());
      end
      drain();

      $display("Checked %0d results for %0d requests over %0d preset codes,",
               sb.checked, sb.requests, $countones(presets_seen));
      $display("with idle cycles on either side and with none.");
      if (sb.errors == 0 && sb.pending() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
